### rtl/core/matrix4x4_multiply_assert.svh
// Assertion macros used by the matrix product RTL.
`ifndef MATRIX4X4_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M4_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix4x4_multiply: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define M4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix4x4_multiply: next-cycle check failed");

`define M4_ASSERT_FOUR(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##3 (cons)) \
    else $error("matrix4x4_multiply: four-cycle check failed");

`endif

### rtl/core/m4x4_pkg.sv
// Types, constants and helper functions for the 4x4 matrix product block.
`timescale 1ns / 1ps
package m4x4_pkg;

  localparam int DIM       = 4;
  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int IDX_W     = 2;
  localparam int STEP_W    = 4;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int TOP_W     = ACC_W - FRAC_W - ELEM_W + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [DIM-1:0][ELEM_W-1:0] row_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // One input word: a row of the left matrix and the same row of the right one.
  typedef struct packed {
    elem_t left_c0;
    elem_t left_c1;
    elem_t left_c2;
    elem_t left_c3;
    elem_t right_c0;
    elem_t right_c1;
    elem_t right_c2;
    elem_t right_c3;
  } in_word_t;

  // One result word: a row of the product.
  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    elem_t            out_c0;
    elem_t            out_c1;
    elem_t            out_c2;
    elem_t            out_c3;
    logic             last_row;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Drop the sixteen fraction bits (floor) and clamp to the 32-bit range.
  function automatic elem_t sat_shift(input acc_t a);
    logic [TOP_W-1:0] top;
    elem_t            res;
    top = a[ACC_W-1:FRAC_W+ELEM_W-1];
    if ((top == '0) || (top == '1)) begin
      res = a[FRAC_W+ELEM_W-1:FRAC_W];
    end else if (a[ACC_W-1]) begin
      res = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### rtl/core/matrix4x4_multiply.sv
// Four words are taken one per cycle while busy is low; the fourth one starts a sweep
// in which four multipliers walk 16 reads of the two row memories through the read
// registers, the product registers, the accumulators and the output register, and the
// product rows come out in order. busy stays high until the pipeline has drained.
// Reset clears the row counter, the sequencer and the pipeline valids; row memories
// hold no reset value and are always fully written before they are read.
`timescale 1ns / 1ps
`include "matrix4x4_multiply_assert.svh"

module matrix4x4_multiply (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  m4x4_pkg::in_word_t    in_data,
  output logic                  out_strobe,
  output m4x4_pkg::out_word_t   out_data
);
  import m4x4_pkg::*;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     row_cnt_r, row_cnt_nxt;
  logic [STEP_W-1:0]    iss_r, iss_nxt;
  logic                 accept;
  logic                 last_word;
  logic                 rd_en;

  row_t                 left_mem  [DIM];
  row_t                 right_mem [DIM];
  row_t                 left_q_r;
  row_t                 right_q_r;

  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic [IDX_W-1:0]     s1_i_r, s1_k_r, s2_i_r, s2_k_r, s3_i_r;
  elem_t                a_sel;
  prod_t                prod_nxt [DIM];
  prod_t                prod_r   [DIM];
  acc_t                 acc_nxt  [DIM];
  acc_t                 acc_r    [DIM];

  logic                 out_strobe_r;
  out_word_t            out_data_r;

  assign accept = start && !busy;

  // The fourth word of a product completes both matrices.
  assign last_word = accept && (row_cnt_r == IDX_W'(DIM - 1));

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (last_word) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (iss_r == STEP_W'(DIM * DIM - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Row counter and read step counter: step bits [3:2] pick the row of the left
  // matrix, bits [1:0] the row of the right matrix (the summation index).
  assign row_cnt_nxt = accept ? row_cnt_r + IDX_W'(1) : row_cnt_r;
  assign iss_nxt     = rd_en ? iss_r + STEP_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      row_cnt_r    <= '0;
      iss_r        <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_cnt_r    <= row_cnt_nxt;
      iss_r        <= iss_nxt;
      s1_v_r       <= rd_en;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r && (s2_k_r == IDX_W'(DIM - 1));
      out_strobe_r <= s3_v_r;
    end
  end

  // Row memories: one whole row written per accepted word, one row read per step.
  always_ff @(posedge clk) begin
    if (accept) begin
      left_mem[row_cnt_r]  <= {in_data.left_c3, in_data.left_c2,
                               in_data.left_c1, in_data.left_c0};
      right_mem[row_cnt_r] <= {in_data.right_c3, in_data.right_c2,
                               in_data.right_c1, in_data.right_c0};
    end
    if (rd_en) begin
      left_q_r  <= left_mem[iss_r[STEP_W-1:IDX_W]];
      right_q_r <= right_mem[iss_r[IDX_W-1:0]];
    end
  end

  // Four multiply lanes, one per result column, then the running sums.
  assign a_sel = left_q_r[s1_k_r];

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      prod_nxt[j] = a_sel * elem_t'(right_q_r[j]);
      acc_nxt[j]  = (s2_k_r == '0) ? ACC_W'(prod_r[j]) : acc_r[j] + ACC_W'(prod_r[j]);
    end
  end

  // Pipeline payload: step tags, products, sums and the result word.
  always_ff @(posedge clk) begin
    s1_i_r <= iss_r[STEP_W-1:IDX_W];
    s1_k_r <= iss_r[IDX_W-1:0];
    s2_i_r <= s1_i_r;
    s2_k_r <= s1_k_r;
    s3_i_r <= s2_i_r;
    for (int j = 0; j < DIM; j++) begin
      prod_r[j] <= prod_nxt[j];
      if (s2_v_r) begin
        acc_r[j] <= acc_nxt[j];
      end
    end
    if (s3_v_r) begin
      out_data_r.row_index <= s3_i_r;
      out_data_r.out_c0    <= sat_shift(acc_r[0]);
      out_data_r.out_c1    <= sat_shift(acc_r[1]);
      out_data_r.out_c2    <= sat_shift(acc_r[2]);
      out_data_r.out_c3    <= sat_shift(acc_r[3]);
      out_data_r.last_row  <= (s3_i_r == IDX_W'(DIM - 1));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // The fourth word starts the read sweep at its first step.
  `M4_ASSERT_NEXT(a_sweep_start, last_word, (state_r == ST_ISSUE) && (iss_r == '0))
  // The pipeline is empty whenever words are being taken.
  `M4_ASSERT_SAME(a_idle_empty, state_r == ST_LOAD, !s1_v_r && !s2_v_r)
  // A partly loaded product only exists while loading.
  `M4_ASSERT_SAME(a_count_load, row_cnt_r != '0, state_r == ST_LOAD)
  // Every product row but the last is followed by the next row of the same product.
  `M4_ASSERT_FOUR(a_row_pitch, out_strobe && !out_data.last_row, out_strobe)

endmodule
